// ===== rtl/core/irctok_pkg.sv =====
// ----------------------------------------------------------------------------
// irctok_pkg
// Types and constants shared by the message line tokenizer modules.
// ----------------------------------------------------------------------------
package irctok_pkg;

    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_LOW_A = 8'h61;
    localparam logic [7:0] CH_LOW_Z = 8'h7A;
    localparam logic [7:0] CASE_OFS = 8'h20;

    localparam logic [1:0] ROLE_PREFIX  = 2'd0;
    localparam logic [1:0] ROLE_COMMAND = 2'd1;
    localparam logic [1:0] ROLE_PARAM   = 2'd2;
    localparam logic [1:0] ROLE_TRAIL   = 2'd3;

    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // queue between front and back
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    typedef enum logic [2:0] {
        PH_LEAD    = 3'd0,
        PH_PREFIX  = 3'd1,
        PH_POSTPFX = 3'd2,
        PH_COMMAND = 3'd3,
        PH_SEP     = 3'd4,
        PH_PARAM   = 3'd5,
        PH_TRAIL   = 3'd6
    } t_phase;

    typedef struct packed {
        logic [7:0] data_in;
        logic       line_end;
    } t_in;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_out;
        logic [1:0] role;
        logic [3:0] param_index;
        logic       token_start;
        logic [3:0] param_count;
        logic       param_overflow;
        logic       has_prefix;
        logic       has_command;
        logic       has_trailing;
        logic       run_last;
    } t_out;

    // all results of one input transaction: released CR, current byte, end record
    typedef struct packed {
        logic cr_vld;
        t_out cr_rec;
        logic byte_vld;
        t_out byte_rec;
        logic end_vld;
        t_out end_rec;
    } t_bundle;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

// ===== rtl/core/irctok_front.sv =====
// ----------------------------------------------------------------------------
// irctok_front
// Accepts line bytes, tracks the token phase and builds the result bundle.
// ----------------------------------------------------------------------------
module irctok_front #(
    parameter int MAX_PARAMS = 15
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  irctok_pkg::t_in    i_data,
    input  irctok_pkg::t_qstat i_qstat,
    output logic               o_stall,
    output logic               o_push,
    output irctok_pkg::t_bundle o_bundle
);
    import irctok_pkg::*;

    typedef struct packed {
        t_phase     phase;
        logic [3:0] pcnt;
        logic       ovf;
        logic       pfx;
        logic       cmd;
        logic       trl;
        logic [3:0] cidx;
        logic       fresh;
    } t_lstate;

    typedef struct packed {
        t_lstate st;
        logic    emit;
        t_out    rec;
    } t_feed;

    localparam logic [3:0] PMAX = 4'(MAX_PARAMS);

    function automatic t_feed feed(t_lstate s, logic [7:0] c);
        t_feed      f;
        logic [7:0] up;
        f      = '0;
        f.st   = s;
        up     = (c >= CH_LOW_A && c <= CH_LOW_Z) ? (c - CASE_OFS) : c;
        f.rec.kind     = KIND_BYTE;
        f.rec.data_out = c;
        unique case (s.phase)
            PH_LEAD, PH_POSTPFX: begin
                if (c == CH_SPACE) begin
                    f.emit = 1'b0;
                end else if (s.phase == PH_LEAD && c == CH_COLON) begin
                    f.st.phase = PH_PREFIX;
                    f.st.pfx   = 1'b1;
                    f.st.fresh = 1'b1;
                end else begin
                    f.st.phase        = PH_COMMAND;
                    f.st.cmd          = 1'b1;
                    f.emit            = 1'b1;
                    f.rec.role        = ROLE_COMMAND;
                    f.rec.data_out    = up;
                    f.rec.token_start = 1'b1;
                end
            end
            PH_PREFIX: begin
                if (c == CH_SPACE) begin
                    f.st.phase = PH_POSTPFX;
                end else begin
                    f.emit            = 1'b1;
                    f.rec.role        = ROLE_PREFIX;
                    f.rec.token_start = s.fresh;
                    f.st.fresh        = 1'b0;
                end
            end
            PH_COMMAND: begin
                if (c == CH_SPACE) begin
                    f.st.phase = PH_SEP;
                end else begin
                    f.emit         = 1'b1;
                    f.rec.role     = ROLE_COMMAND;
                    f.rec.data_out = up;
                end
            end
            PH_SEP: begin
                if (c == CH_SPACE) begin
                    f.emit = 1'b0;
                end else if (c == CH_COLON) begin
                    f.st.phase = PH_TRAIL;
                    f.st.trl   = 1'b1;
                    f.st.fresh = 1'b1;
                end else begin
                    // open a parameter; saturate the count at the limit
                    f.st.phase = PH_PARAM;
                    f.st.cidx  = s.pcnt;
                    if (s.pcnt < PMAX) begin
                        f.st.pcnt = s.pcnt + 4'd1;
                    end else begin
                        f.st.ovf = 1'b1;
                    end
                    f.emit            = 1'b1;
                    f.rec.role        = ROLE_PARAM;
                    f.rec.param_index = s.pcnt;
                    f.rec.token_start = 1'b1;
                end
            end
            PH_PARAM: begin
                if (c == CH_SPACE) begin
                    f.st.phase = PH_SEP;
                end else begin
                    f.emit            = 1'b1;
                    f.rec.role        = ROLE_PARAM;
                    f.rec.param_index = s.cidx;
                end
            end
            default: begin
                f.emit            = 1'b1;
                f.rec.role        = ROLE_TRAIL;
                f.rec.token_start = s.fresh;
                f.st.fresh        = 1'b0;
            end
        endcase
        return f;
    endfunction

    localparam t_lstate ST_CLEAR = '{phase: PH_LEAD, default: '0};

    t_lstate r_st, n_st;
    logic    r_held_cr, n_held_cr;
    t_feed   f_cr, f_byte;
    t_lstate s_mid;
    logic    accept, stripped, hold_now;

    assign o_stall = i_qstat.full;
    assign accept  = i_valid && !i_qstat.full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st      <= ST_CLEAR;
            r_held_cr <= 1'b0;
        end else if (accept) begin
            r_st      <= n_st;
            r_held_cr <= n_held_cr;
        end
    end

    always_comb begin
        stripped = r_held_cr && i_data.line_end && (i_data.data_in == CH_LF);
        hold_now = (i_data.data_in == CH_CR) && !i_data.line_end;

        // release a held CR ahead of the current byte
        f_cr  = feed(r_st, CH_CR);
        s_mid = (r_held_cr && !stripped) ? f_cr.st : r_st;
        f_byte = feed(s_mid, i_data.data_in);

        o_bundle          = '0;
        o_bundle.cr_vld   = r_held_cr && !stripped && f_cr.emit;
        o_bundle.cr_rec   = f_cr.rec;
        o_bundle.byte_vld = !stripped && !hold_now && f_byte.emit;
        o_bundle.byte_rec = f_byte.rec;

        n_st = (stripped || hold_now) ? s_mid : f_byte.st;

        o_bundle.end_vld                = i_data.line_end;
        o_bundle.end_rec.kind           = KIND_END;
        o_bundle.end_rec.param_count    = n_st.pcnt;
        o_bundle.end_rec.param_overflow = n_st.ovf;
        o_bundle.end_rec.has_prefix     = n_st.pfx;
        o_bundle.end_rec.has_command    = n_st.cmd;
        o_bundle.end_rec.has_trailing   = n_st.trl;

        n_held_cr = hold_now;
        if (i_data.line_end) begin
            n_st = ST_CLEAR;
        end

        o_push = accept && (o_bundle.cr_vld || o_bundle.byte_vld || o_bundle.end_vld);
    end

endmodule

// ===== rtl/core/irctok_queue.sv =====
// ----------------------------------------------------------------------------
// irctok_queue
// Short FIFO of result bundles between the front and back sections.
// ----------------------------------------------------------------------------
module irctok_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  irctok_pkg::t_bundle i_bundle,
    input  logic                i_pop,
    output irctok_pkg::t_bundle o_head,
    output irctok_pkg::t_qstat  o_qstat
);
    import irctok_pkg::*;

    t_bundle        r_mem [QDEPTH];
    logic [QAW-1:0] r_wp, r_rp;
    logic [QAW:0]   r_cnt;
    logic           do_push, do_pop;

    assign o_qstat.full  = (r_cnt == (QAW+1)'(QDEPTH));
    assign o_qstat.empty = (r_cnt == '0);
    assign do_push       = i_push && !o_qstat.full;
    assign do_pop        = i_pop && !o_qstat.empty;
    assign o_head        = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_bundle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wp <= r_wp + 1'b1;
            if (do_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (QAW+1)'(do_push) - (QAW+1)'(do_pop);
        end
    end

endmodule

// ===== rtl/core/irctok_back.sv =====
// ----------------------------------------------------------------------------
// irctok_back
// Unpacks queued bundles into single result records behind an output register.
// ----------------------------------------------------------------------------
module irctok_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  irctok_pkg::t_bundle i_head,
    input  irctok_pkg::t_qstat  i_qstat,
    output logic                o_pop,
    input  logic                i_stall,
    output logic                o_valid,
    output irctok_pkg::t_out    o_data
);
    import irctok_pkg::*;

    logic [2:0] r_done;
    logic       r_valid;
    t_out       r_out;
    logic [2:0] remain, sel, rest;
    logic       load;
    t_out       rec;

    always_comb begin
        remain = {i_head.end_vld, i_head.byte_vld, i_head.cr_vld} & ~r_done;
        sel    = remain & (~remain + 3'd1);
        rest   = remain & ~sel;
        case (1'b1)
            sel[0]:  rec = i_head.cr_rec;
            sel[1]:  rec = i_head.byte_rec;
            default: rec = i_head.end_rec;
        endcase
        rec.run_last = (rest == 3'b000);
        load  = !i_qstat.empty && (!r_valid || !i_stall);
        o_pop = load && (rest == 3'b000);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_done  <= '0;
        end else if (load) begin
            r_valid <= 1'b1;
            r_done  <= (rest == 3'b000) ? 3'b000 : (r_done | sel);
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= rec;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_out;

endmodule

// ===== rtl/core/irc_message_line_tokenizer_unit.sv =====
// ----------------------------------------------------------------------------
// irc_message_line_tokenizer_unit
// Splits a message line into tagged prefix, command, parameter and trailing
// bytes and closes each line with an end record.
// ----------------------------------------------------------------------------
// Input channel (i_valid / o_stall / i_data): one line byte per transaction,
// line_end set on the final byte. Output channel (o_valid / i_stall / o_data):
// one result record per transaction, run_last set on the last record that an
// input byte causes. An input byte yields zero to three records: a released
// CR, the byte itself and, on line_end, the end record.
// The first record of a byte passes through the bundle queue and then the
// output register before it is valid. The front section takes one byte per
// cycle while the four-entry bundle queue has room; the back section issues
// one record per cycle while the receiver does not stall, so the sustained
// rate is one byte per cycle for single-record bytes.
// Reset clears the line state, the held CR, the queue and the output register.
// When the receiver stalls, the output record holds, the queue fills and
// o_stall rises once it is full.
// ----------------------------------------------------------------------------
module irc_message_line_tokenizer_unit #(
    parameter int MAX_PARAMS = 15
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  irctok_pkg::t_in  i_data,
    output logic             o_valid,
    input  logic             i_stall,
    output irctok_pkg::t_out o_data
);
    import irctok_pkg::*;

    logic    push, pop;
    t_bundle bundle, head;
    t_qstat  qstat;

    irctok_front #(
        .MAX_PARAMS (MAX_PARAMS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_data   (i_data),
        .i_qstat  (qstat),
        .o_stall  (o_stall),
        .o_push   (push),
        .o_bundle (bundle)
    );

    irctok_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_bundle (bundle),
        .i_pop    (pop),
        .o_head   (head),
        .o_qstat  (qstat)
    );

    irctok_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .i_qstat (qstat),
        .o_pop   (pop),
        .i_stall (i_stall),
        .o_valid (o_valid),
        .o_data  (o_data)
    );

endmodule

// ===== rtl/core/irctok_checker.sv =====
// ----------------------------------------------------------------------------
// irctok_checker
// Port-level checks on the tokenizer output channel.
// ----------------------------------------------------------------------------
module irctok_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_valid,
    input logic             i_stall,
    input irctok_pkg::t_out o_data
);
    import irctok_pkg::*;

    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("stalled output transaction changed");

    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.kind == KIND_END |-> o_data.run_last)
        else $error("end record without run_last");

    a_byte_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.kind == KIND_BYTE |->
            o_data.param_count == 4'd0 && !o_data.param_overflow &&
            !o_data.has_prefix && !o_data.has_command && !o_data.has_trailing)
        else $error("content record carries summary fields");

    a_cmd_upper: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.kind == KIND_BYTE && o_data.role == ROLE_COMMAND |->
            !(o_data.data_out >= CH_LOW_A && o_data.data_out <= CH_LOW_Z))
        else $error("lower-case command byte");

endmodule

bind irc_message_line_tokenizer_unit irctok_checker u_irctok_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_data  (o_data)
);
